FILE: design/jads_pkg.sv
`timescale 1ns / 1ps

package jads_pkg;

    // converter and calibration constants
    localparam int ADC_FULL_SCALE = 1023;
    localparam int CAL_WINDOW     = 16;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 20;
    localparam int CNT_W    = 10;
    localparam int EDGE_W   = 12;   // signed band edges and segment spans
    localparam int DIFF_W   = 11;   // offset of a sample inside its segment
    localparam int SPAN_W   = 25;   // output span of a segment, q.8
    localparam int PROD_W   = DIFF_W + 1 + SPAN_W;
    localparam int VALUE_W  = 24;
    localparam int SUMV_W   = 36;   // base plus signed quotient

    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 11;

    localparam logic [SAMPLE_W-1:0]      CENTER_RESET = SAMPLE_W'(512);
    localparam logic signed [EDGE_W-1:0] ADC_FS_EDGE  = EDGE_W'(ADC_FULL_SCALE);
    localparam logic [DIV_DEN_W-1:0]     CAL_WIN_DEN  = DIV_DEN_W'(CAL_WINDOW);

    localparam logic signed [SUMV_W-1:0] OUT_MAX_Q8 = SUMV_W'(8388607);
    localparam logic signed [SUMV_W-1:0] OUT_MIN_Q8 = -SUMV_W'(8388608);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_START,
        S_DIV,
        S_FIX,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        REG_X_OUT_MIN = 3'd0,
        REG_X_OUT_MAX = 3'd1,
        REG_Y_OUT_MIN = 3'd2,
        REG_Y_OUT_MAX = 3'd3,
        REG_DEAD_BAND = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] x_out_min;
        logic signed [15:0] x_out_max;
        logic signed [15:0] y_out_min;
        logic signed [15:0] y_out_max;
        logic [8:0]         dead_band;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

FILE: design/jads_apb_regs.sv
`timescale 1ns / 1ps

module jads_apb_regs
    import jads_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_out_min <= 16'sd0;
            r_cfg.x_out_max <= 16'sd1023;
            r_cfg.y_out_min <= 16'sd0;
            r_cfg.y_out_max <= 16'sd1023;
            r_cfg.dead_band <= 9'd16;
        end else if (w_wr) begin
            case (w_idx)
                REG_X_OUT_MIN: r_cfg.x_out_min <= pwdata[15:0];
                REG_X_OUT_MAX: r_cfg.x_out_max <= pwdata[15:0];
                REG_Y_OUT_MIN: r_cfg.y_out_min <= pwdata[15:0];
                REG_Y_OUT_MAX: r_cfg.y_out_max <= pwdata[15:0];
                REG_DEAD_BAND: r_cfg.dead_band <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_X_OUT_MIN: prdata = {16'd0, r_cfg.x_out_min};
            REG_X_OUT_MAX: prdata = {16'd0, r_cfg.x_out_max};
            REG_Y_OUT_MIN: prdata = {16'd0, r_cfg.y_out_min};
            REG_Y_OUT_MAX: prdata = {16'd0, r_cfg.y_out_max};
            REG_DEAD_BAND: prdata = {23'd0, r_cfg.dead_band};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/jads_divider.sv
`timescale 1ns / 1ps

module jads_divider
    import jads_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(DIV_NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_NUM_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [DIV_NUM_W-1:0] r_num;   // dividend shifts out, quotient shifts in
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W:0]   w_rem_sub;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] n_rem;

    // one restoring step per cycle
    assign w_rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign n_rem     = w_ge ? w_rem_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;

endmodule

FILE: design/joystick_axis_deadzone_scaler.sv
`timescale 1ns / 1ps

// joystick axis dead band scaler: each transfer carries a 10-bit converter
// reading for the x or y axis plus an action bit. a conversion reading that
// lies strictly inside center +/- dead_band returns 0 with in_dead_band set;
// any other reading is mapped linearly onto the lower half (out_min up to the
// midpoint) or the upper half (midpoint up to out_max) of that axis's output
// range, as a signed q.8 value saturated to 24 bits, with the division
// truncating toward zero. a calibration reading is summed per axis, and every
// CAL_WINDOW readings the center becomes their truncated mean (center_updated
// set on that result). one item is worked at a time: a reading that needs the
// divide passes through prep, multiply, a 34-step restoring divider shared by
// the segment map and the calibration mean, then fix-up (a calibration reading
// that closes the window skips the multiply), and the next transfer is taken
// once its result is in the output register. a dead band hit, a zero-width
// segment or a calibration reading that does not close the window skips the
// multiply, the divide and the fix-up. a full output register held by the
// receiver adds its wait. the result sits in an output register, so the next
// transfer is taken while a result still waits downstream. configuration is
// written over the apb port at byte address 4*index; the user must write it
// only while the block is idle, as the block itself does not enforce this.

module joystick_axis_deadzone_scaler
    import jads_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic                      i_axis_sel,
    input  logic [SAMPLE_W-1:0]       i_sample,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_scaled_value,
    output logic                      o_in_dead_band,
    output logic                      o_center_updated
);

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    t_state r_state, n_state;

    // captured item
    logic                r_action;
    logic                r_axis;
    logic [SAMPLE_W-1:0] r_sample;

    // calibration state per axis
    logic [SAMPLE_W-1:0] r_x_center, r_y_center;
    logic [SUM_W-1:0]    r_x_sum, r_y_sum;
    logic [CNT_W-1:0]    r_x_cnt, r_y_cnt;

    // segment operands
    logic [DIFF_W-1:0]        r_diff;
    logic signed [SPAN_W-1:0] r_span;
    logic signed [EDGE_W-1:0] r_den;
    logic signed [SPAN_W-1:0] r_base;
    logic [DIV_NUM_W-1:0]     r_num_mag;
    logic [DIV_DEN_W-1:0]     r_den_mag;
    logic                     r_neg;

    // finished result before the output register
    logic signed [VALUE_W-1:0] r_res_value;
    logic                      r_res_inband;
    logic                      r_res_upd;

    // output register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_inband;
    logic                      r_out_upd;

    logic w_accept;
    logic w_out_free;
    logic w_load_out;

    // ---------------------------------------------------------------
    // configuration registers and shared divider
    // ---------------------------------------------------------------
    jads_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    jads_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_div_req.start = (r_state == S_START);
    assign w_div_req.num   = r_num_mag;
    assign w_div_req.den   = r_den_mag;

    // ---------------------------------------------------------------
    // prep: band test and segment selection for the captured reading
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0]      w_center;
    logic signed [15:0]       w_omin, w_omax;
    logic signed [16:0]       w_mm_sum;
    logic signed [SPAN_W-1:0] w_mid8, w_min8, w_max8;
    logic signed [EDGE_W-1:0] w_smp, w_edge_lo, w_edge_hi, w_up_off;
    logic                     w_inband, w_lower;
    logic [DIFF_W-1:0]        w_seg_diff;
    logic signed [SPAN_W-1:0] w_seg_span, w_seg_base;
    logic signed [EDGE_W-1:0] w_seg_den;

    assign w_center = r_axis ? r_y_center : r_x_center;
    assign w_omin   = r_axis ? w_cfg.y_out_min : w_cfg.x_out_min;
    assign w_omax   = r_axis ? w_cfg.y_out_max : w_cfg.x_out_max;

    // midpoint kept exact in q.8 as (min + max) * 128
    assign w_mm_sum = {w_omin[15], w_omin} + {w_omax[15], w_omax};
    assign w_mid8   = {w_mm_sum[16], w_mm_sum, 7'd0};
    assign w_min8   = {w_omin[15], w_omin, 8'd0};
    assign w_max8   = {w_omax[15], w_omax, 8'd0};

    assign w_smp     = $signed({2'b00, r_sample});
    assign w_edge_lo = $signed({2'b00, w_center}) - $signed({3'b000, w_cfg.dead_band});
    assign w_edge_hi = $signed({2'b00, w_center}) + $signed({3'b000, w_cfg.dead_band});
    assign w_up_off  = w_smp - w_edge_hi;

    assign w_inband = (w_smp > w_edge_lo) && (w_smp < w_edge_hi);
    // a reading on a band edge leaves the band and takes the segment that meets that edge
    assign w_lower  = (w_smp <= w_edge_lo);

    assign w_seg_diff = w_lower ? {1'b0, r_sample} : w_up_off[DIFF_W-1:0];
    assign w_seg_span = w_lower ? (w_mid8 - w_min8) : (w_max8 - w_mid8);
    assign w_seg_base = w_lower ? w_min8 : w_mid8;
    // span can go negative when center minus band drops below zero or center plus band passes full scale
    assign w_seg_den  = w_lower ? w_edge_lo : (ADC_FS_EDGE - w_edge_hi);

    // calibration accumulate
    logic [SUM_W-1:0] w_cal_sum, w_cal_nsum;
    logic [CNT_W-1:0] w_cal_cnt;
    logic [CNT_W:0]   w_cal_ncnt;
    logic             w_cal_win;

    assign w_cal_sum  = r_axis ? r_y_sum : r_x_sum;
    assign w_cal_cnt  = r_axis ? r_y_cnt : r_x_cnt;
    assign w_cal_nsum = w_cal_sum + {{(SUM_W-SAMPLE_W){1'b0}}, r_sample};
    assign w_cal_ncnt = {1'b0, w_cal_cnt} + 1'b1;
    assign w_cal_win  = (w_cal_ncnt >= CAL_WIN_DEN);

    // ---------------------------------------------------------------
    // multiply: one signed product, then sign and magnitudes for the divider
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] w_prod, w_prod_abs;
    logic signed [EDGE_W-1:0] w_den_abs;

    assign w_prod     = $signed({1'b0, r_diff}) * r_span;
    assign w_prod_abs = w_prod[PROD_W-1] ? -w_prod : w_prod;
    assign w_den_abs  = r_den[EDGE_W-1] ? -r_den : r_den;

    // ---------------------------------------------------------------
    // fix-up: restore sign, add segment base, saturate
    // ---------------------------------------------------------------
    logic signed [SUMV_W-1:0]  w_q_ext, w_q_signed, w_sum;
    logic signed [VALUE_W-1:0] w_sat;

    assign w_q_ext    = $signed({{(SUMV_W-DIV_NUM_W){1'b0}}, w_div_rsp.quo});
    assign w_q_signed = r_neg ? -w_q_ext : w_q_ext;
    assign w_sum      = w_q_signed + {{(SUMV_W-SPAN_W){r_base[SPAN_W-1]}}, r_base};

    always_comb begin
        if (w_sum > OUT_MAX_Q8) begin
            w_sat = OUT_MAX_Q8[VALUE_W-1:0];
        end else if (w_sum < OUT_MIN_Q8) begin
            w_sat = OUT_MIN_Q8[VALUE_W-1:0];
        end else begin
            w_sat = w_sum[VALUE_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (r_state == S_FIN) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                if (r_action) begin
                    n_state = w_cal_win ? S_START : S_FIN;
                end else if (w_inband || (w_seg_den == '0)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (w_div_rsp.done) n_state = S_FIX;
            end
            S_FIX:   n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // architectural state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_x_center  <= CENTER_RESET;
            r_y_center  <= CENTER_RESET;
            r_x_sum     <= '0;
            r_y_sum     <= '0;
            r_x_cnt     <= '0;
            r_y_cnt     <= '0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if ((r_state == S_PREP) && r_action) begin
                if (r_axis) begin
                    r_y_sum <= w_cal_win ? '0 : w_cal_nsum;
                    r_y_cnt <= w_cal_win ? '0 : w_cal_ncnt[CNT_W-1:0];
                end else begin
                    r_x_sum <= w_cal_win ? '0 : w_cal_nsum;
                    r_x_cnt <= w_cal_win ? '0 : w_cal_ncnt[CNT_W-1:0];
                end
            end

            // mean of the window lands when the divider is done
            if ((r_state == S_FIX) && r_action) begin
                if (r_axis) begin
                    r_y_center <= w_div_rsp.quo[SAMPLE_W-1:0];
                end else begin
                    r_x_center <= w_div_rsp.quo[SAMPLE_W-1:0];
                end
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_axis   <= i_axis_sel;
            r_sample <= i_sample;
        end

        case (r_state)
            S_PREP: begin
                r_res_upd <= 1'b0;
                if (r_action) begin
                    r_res_value  <= '0;
                    r_res_inband <= 1'b0;
                    r_num_mag    <= {{(DIV_NUM_W-SUM_W){1'b0}}, w_cal_nsum};
                    r_den_mag    <= CAL_WIN_DEN;
                    r_neg        <= 1'b0;
                end else begin
                    r_res_inband <= w_inband;
                    // zero-width segment falls through with the midpoint
                    r_res_value  <= w_inband ? '0 : w_mid8[VALUE_W-1:0];
                    r_diff       <= w_seg_diff;
                    r_span       <= w_seg_span;
                    r_den        <= w_seg_den;
                    r_base       <= w_seg_base;
                end
            end
            S_MUL: begin
                r_num_mag <= w_prod_abs[DIV_NUM_W-1:0];
                r_den_mag <= w_den_abs[DIV_DEN_W-1:0];
                r_neg     <= w_prod[PROD_W-1] ^ r_den[EDGE_W-1];
            end
            S_FIX: begin
                if (r_action) begin
                    r_res_value  <= '0;
                    r_res_inband <= 1'b0;
                    r_res_upd    <= 1'b1;
                end else begin
                    r_res_value  <= w_sat;
                end
            end
            default: ;
        endcase

        if (w_load_out) begin
            r_out_value  <= r_res_value;
            r_out_inband <= r_res_inband;
            r_out_upd    <= r_res_upd;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_scaled_value   = r_out_value;
    assign o_in_dead_band   = r_out_inband;
    assign o_center_updated = r_out_upd;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_in_dead_band && o_center_updated))
        else $error("dead band and center update flagged on one result");

    a_band_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_dead_band) |-> (o_scaled_value == '0))
        else $error("dead band result carries a nonzero value");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_out_valid && i_out_stall) |=> (r_state == S_FIN))
        else $error("finished result left while output register was full");

endmodule

FILE: bench/joystick_axis_deadzone_scaler_check.sv
`timescale 1ns / 1ps

module joystick_axis_deadzone_scaler_check
    import jads_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_action,
    input  logic                      i_axis_sel,
    input  logic [SAMPLE_W-1:0]       i_sample,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [VALUE_W-1:0] i_scaled_value,
    input  logic                      i_in_dead_band,
    input  logic                      i_center_updated,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam longint VALUE_HI = 64'sd8388607;
    localparam longint VALUE_LO = -64'sd8388608;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      dead;
        logic                      upd;
    } axis_result_t;

    logic signed [15:0]  out_min [2];
    logic signed [15:0]  out_max [2];
    logic [8:0]          band;
    logic [SAMPLE_W-1:0] center  [2];
    logic [SUM_W-1:0]    cal_sum [2];
    int                  cal_count [2];

    axis_result_t expected_q [$];
    int           fails    = 0;
    int           reported = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // piecewise map of one conversion reading, q.8 out
    function automatic axis_result_t map_reading(longint s, longint ctr, longint bw,
                                                 longint omin, longint omax);
        longint       mid8, lo, hi, a, b, v;
        axis_result_t r;
        r    = '0;
        mid8 = (omin + omax) * 128;
        if (s > ctr - bw && s < ctr + bw) begin
            r.dead = 1'b1;
            return r;
        end
        if (s <= ctr - bw) begin
            lo = 0;
            hi = ctr - bw;
            a  = omin * 256;
            b  = mid8;
        end else begin
            lo = ctr + bw;
            hi = ADC_FULL_SCALE;
            a  = mid8;
            b  = omax * 256;
        end
        if (hi == lo) begin
            v = mid8;
        end else begin
            v = a + ((s - lo) * (b - a)) / (hi - lo);
        end
        if (v > VALUE_HI) v = VALUE_HI;
        if (v < VALUE_LO) v = VALUE_LO;
        r.value = v[VALUE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        axis_result_t     want;
        int               ax;
        logic [SUM_W-1:0] nsum;
        if (!i_rst_n) begin
            out_min[0]   = '0;
            out_max[0]   = 16'sd1023;
            out_min[1]   = '0;
            out_max[1]   = 16'sd1023;
            band         = 9'd16;
            center[0]    = CENTER_RESET;
            center[1]    = CENTER_RESET;
            cal_sum[0]   = '0;
            cal_sum[1]   = '0;
            cal_count[0] = 0;
            cal_count[1] = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_X_OUT_MIN: out_min[0] = pwdata[15:0];
                    REG_X_OUT_MAX: out_max[0] = pwdata[15:0];
                    REG_Y_OUT_MIN: out_min[1] = pwdata[15:0];
                    REG_Y_OUT_MAX: out_max[1] = pwdata[15:0];
                    REG_DEAD_BAND: band       = pwdata[8:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fails++;
                    if (reported < 10) begin
                        $display("unexpected result: value %0d dead %0b upd %0b",
                                 i_scaled_value, i_in_dead_band, i_center_updated);
                    end
                    reported++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.value !== i_scaled_value || want.dead !== i_in_dead_band ||
                        want.upd !== i_center_updated) begin
                        fails++;
                        if (reported < 10) begin
                            $display("mismatch: expected value %0d dead %0b upd %0b, got %0d %0b %0b",
                                     want.value, want.dead, want.upd,
                                     i_scaled_value, i_in_dead_band, i_center_updated);
                        end
                        reported++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ax   = i_axis_sel;
                want = '0;
                if (i_action) begin
                    // calibration: window sum, center is the truncated mean
                    nsum = cal_sum[ax] + i_sample;
                    if (cal_count[ax] + 1 >= CAL_WINDOW) begin
                        center[ax]    = SAMPLE_W'(nsum / CAL_WINDOW);
                        cal_sum[ax]   = '0;
                        cal_count[ax] = 0;
                        want.upd      = 1'b1;
                    end else begin
                        cal_sum[ax]   = nsum;
                        cal_count[ax] = cal_count[ax] + 1;
                    end
                end else begin
                    want = map_reading(longint'(i_sample), longint'(center[ax]),
                                       longint'(band), longint'(out_min[ax]),
                                       longint'(out_max[ax]));
                end
                expected_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

FILE: bench/joystick_axis_deadzone_scaler_test.sv
`timescale 1ns / 1ps

module joystick_axis_deadzone_scaler_test;
    import jads_pkg::*;

    localparam int ITEMS          = 1200;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int DRAIN_MARGIN   = 50;    // about one divide pass
    localparam int QUIET_LO       = 500;   // window with no idling on either side
    localparam int QUIET_HI       = 700;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [4:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_action;
    logic                      i_axis_sel;
    logic [SAMPLE_W-1:0]       i_sample;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [VALUE_W-1:0] o_scaled_value;
    logic                      o_in_dead_band;
    logic                      o_center_updated;

    int fail_count;
    int pending;
    int sent         = 0;
    int results      = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    bit held         = 1'b0;

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    joystick_axis_deadzone_scaler u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_axis_sel       (i_axis_sel),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_scaled_value   (o_scaled_value),
        .o_in_dead_band   (o_in_dead_band),
        .o_center_updated (o_center_updated)
    );

    // checker watches both channels and the config port, predicts and compares
    joystick_axis_deadzone_scaler_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_axis_sel       (i_axis_sel),
        .i_sample         (i_sample),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_scaled_value   (o_scaled_value),
        .i_in_dead_band   (o_in_dead_band),
        .i_center_updated (o_center_updated),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // receiver: random stalls, one long hold-off, and a quiet window
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results = results + 1;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   = hold_left - 1;
        end else if (results == 300 && !held) begin
            // hold off long enough that the block backs up and stalls its input
            held        = 1'b1;
            hold_left   = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !(results >= QUIET_LO && results < QUIET_HI) &&
                           ($urandom_range(99) < 12);
        end
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // apb write: setup, access, then the bus goes idle
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        // wait first so the checker's count includes the last transfer
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_MARGIN) @(posedge i_clk);
    endtask

    // one input transfer with random idle cycles ahead of it
    task automatic send_item(input logic act, input logic ax, input logic [SAMPLE_W-1:0] s);
        while (!(sent >= QUIET_LO && sent < QUIET_HI) && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_axis_sel <= ax;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
        if (v < 0) return '0;
        if (v > ADC_FULL_SCALE) return SAMPLE_W'(ADC_FULL_SCALE);
        return SAMPLE_W'(v);
    endfunction

    // conversion reading biased toward the field extremes, the nominal center and the band edges around it
    function automatic logic [SAMPLE_W-1:0] pick_near(int ctr, int bw);
        case ($urandom_range(0, 11))
            0:       return clamp_sample(0);
            1:       return clamp_sample(ADC_FULL_SCALE);
            2:       return clamp_sample(ctr - bw);
            3:       return clamp_sample(ctr - bw - 1);
            4:       return clamp_sample(ctr - bw + 1);
            5:       return clamp_sample(ctr + bw);
            6:       return clamp_sample(ctr + bw - 1);
            7:       return clamp_sample(ctr + bw + 1);
            8:       return clamp_sample(ctr);
            default: return SAMPLE_W'($urandom_range(0, ADC_FULL_SCALE));
        endcase
    endfunction

    // output range end, extremes weighted in
    function automatic logic [15:0] pick_out();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 2047) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_band();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 511;
            2:       return $urandom_range(0, 40);
            default: return $urandom_range(0, 511);
        endcase
    endfunction

    initial begin
        int                  probe_x [7];
        int                  probe_y [5];
        int                  aim [2];
        int                  phase;
        int                  mode;
        int                  bw;
        int                  tgt;
        int                  n;
        logic                ax;
        logic                ax2;
        logic                act;
        logic [SAMPLE_W-1:0] s;

        probe_x = '{0, 1023, 496, 497, 512, 527, 528};
        probe_y = '{0, 1023, 495, 529, 500};
        aim     = '{512, 512};

        // every input known from time zero
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_action   <= 1'b0;
        i_axis_sel <= 1'b0;
        i_sample   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: center 512, band 16; band edges take the near segment
        foreach (probe_x[i]) send_item(1'b0, 1'b0, SAMPLE_W'(probe_x[i]));
        foreach (probe_y[i]) send_item(1'b0, 1'b1, SAMPLE_W'(probe_y[i]));
        // calibration readings at the field extremes
        send_item(1'b1, 1'b0, SAMPLE_W'(ADC_FULL_SCALE));
        send_item(1'b1, 1'b1, '0);

        // empty band: reading at the center goes to the lower segment
        wait_drained();
        write_reg(REG_DEAD_BAND, 16'd0);
        send_item(1'b0, 1'b0, 10'd512);
        send_item(1'b0, 1'b0, 10'd511);
        send_item(1'b0, 1'b0, 10'd513);

        phase = 0;
        while (sent < ITEMS) begin
            // new settings only while the block is idle
            wait_drained();
            bw = pick_band();
            write_reg(REG_X_OUT_MIN, pick_out());
            write_reg(REG_X_OUT_MAX, pick_out());
            write_reg(REG_Y_OUT_MIN, pick_out());
            write_reg(REG_Y_OUT_MAX, pick_out());
            write_reg(REG_DEAD_BAND, 16'(bw));

            mode = (phase < 3) ? phase : $urandom_range(0, 4);
            ax   = 1'($urandom_range(0, 1));
            if (mode <= 2) begin
                // zero-width lower segment, zero-width upper segment, or any center
                if (mode == 0) tgt = bw;
                else if (mode == 1) tgt = ADC_FULL_SCALE - bw;
                else tgt = $urandom_range(0, ADC_FULL_SCALE);
                // 32 readings close at least one full window whatever the count was
                repeat (32) begin
                    if (mode == 2) s = clamp_sample(tgt + $urandom_range(0, 16) - 8);
                    else s = clamp_sample(tgt);
                    send_item(1'b1, ax, s);
                end
                aim[ax] = tgt;
                n = $urandom_range(20, 60);
                repeat (n) begin
                    ax2 = ($urandom_range(0, 3) == 0) ? ~ax : ax;
                    send_item(1'b0, ax2, pick_near(aim[ax2], bw));
                end
            end else begin
                // free mix of conversions and stray calibration readings
                n = $urandom_range(40, 80);
                repeat (n) begin
                    ax2 = 1'($urandom_range(0, 1));
                    act = ($urandom_range(0, 3) == 0);
                    if (act) s = SAMPLE_W'($urandom_range(0, ADC_FULL_SCALE));
                    else s = pick_near(aim[ax2], bw);
                    send_item(act, ax2, s);
                end
            end
            phase++;
        end

        // all stimulus taken: wait out the last results
        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/jads_pkg.sv
design/jads_apb_regs.sv
design/jads_divider.sv
design/joystick_axis_deadzone_scaler.sv
bench/joystick_axis_deadzone_scaler_check.sv
bench/joystick_axis_deadzone_scaler_test.sv
